@@ design/alclk_pkg.sv @@
// Package with the shared types, constants and helper functions of the alarm clock controller.
`timescale 1ns / 1ps
`default_nettype none

package alclk_pkg;

  localparam logic [5:0] MINUTE_TOP  = 6'd59;
  localparam logic [4:0] HOUR_TOP    = 5'd23;
  localparam logic [7:0] RING_RESET  = 8'd60;
  localparam logic [7:0] BLINK_RESET = 8'd50;
  localparam logic [7:0] COUNT_MAX   = 8'd255;

  localparam int unsigned ADDR_W = 3;

  localparam logic REG_RING_DURATION = 1'b0;
  localparam logic REG_BLINK_HALF    = 1'b1;

  typedef struct packed {
    logic       function_click;
    logic       move_click;
    logic       up_click;
    logic       down_click;
    logic       enable_click;
    logic       leave_request;
    logic       second_tick;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
    logic       centi_tick;
  } in_item_t;

  typedef struct packed {
    logic [4:0] shown_hour;
    logic [5:0] shown_minute;
    logic       is_enabled;
    logic       is_sounding;
    logic       in_setting;
    logic       cursor_shown;
    logic       cursor_on_hour;
    logic       display_changed;
  } out_item_t;

  typedef struct packed {
    logic [7:0] ring_duration_seconds;
    logic [7:0] blink_half_period_ticks;
  } cfg_t;

  function automatic logic [5:0] wrap_step(input logic [5:0] v, input logic [5:0] top,
                                           input logic up);
    logic [5:0] r;
    if (up) begin
      r = (v >= top) ? 6'd0 : v + 6'd1;
    end else begin
      r = (v == 6'd0) ? top : v - 6'd1;
    end
    return r;
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v < COUNT_MAX) ? v + 8'd1 : v;
  endfunction

endpackage

`default_nettype wire

@@ design/alclk_regs.sv @@
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module alclk_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [alclk_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output alclk_pkg::cfg_t                  cfg
);
  import alclk_pkg::*;

  logic [7:0] ring_duration_seconds;
  logic [7:0] blink_half_period_ticks;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_duration_seconds   <= RING_RESET;
      blink_half_period_ticks <= BLINK_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_RING_DURATION: ring_duration_seconds   <= pwdata[7:0];
        REG_BLINK_HALF:    blink_half_period_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RING_DURATION: prdata = {24'd0, ring_duration_seconds};
      REG_BLINK_HALF:    prdata = {24'd0, blink_half_period_ticks};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg.ring_duration_seconds   = ring_duration_seconds;
  assign cfg.blink_half_period_ticks = blink_half_period_ticks;

endmodule

`default_nettype wire

@@ design/alclk_core.sv @@
// Controller state and the single-pass update that turns one transaction into a result.
`timescale 1ns / 1ps
`default_nettype none

module alclk_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire alclk_pkg::in_item_t item,
  input  wire alclk_pkg::cfg_t     cfg,
  output alclk_pkg::out_item_t     result
);
  import alclk_pkg::*;

  logic [4:0] saved_hour, saved_hour_next;
  logic [5:0] saved_minute, saved_minute_next;
  logic [4:0] edit_hour, edit_hour_next;
  logic [5:0] edit_minute, edit_minute_next;
  logic       setting_active, setting_active_next;
  logic       editing_hour, editing_hour_next;
  logic       armed, armed_next;
  logic       ringing, ringing_next;
  logic [7:0] ring_count, ring_count_next;
  logic       blink_phase, blink_phase_next;
  logic [7:0] blink_count, blink_count_next;
  logic       changed;

  always_comb begin
    saved_hour_next     = saved_hour;
    saved_minute_next   = saved_minute;
    edit_hour_next      = edit_hour;
    edit_minute_next    = edit_minute;
    setting_active_next = setting_active;
    editing_hour_next   = editing_hour;
    armed_next          = armed;
    ringing_next        = ringing;
    ring_count_next     = ring_count;
    blink_phase_next    = blink_phase;
    blink_count_next    = blink_count;
    changed             = 1'b0;

    if (item.function_click) begin
      if (!setting_active) begin
        edit_hour_next      = saved_hour;
        edit_minute_next    = saved_minute;
        setting_active_next = 1'b1;
        editing_hour_next   = 1'b0;
        blink_phase_next    = 1'b1;
        blink_count_next    = 8'd0;
      end else begin
        saved_hour_next     = edit_hour;
        saved_minute_next   = edit_minute;
        setting_active_next = 1'b0;
        blink_phase_next    = 1'b0;
      end
      changed = 1'b1;
    end else if (setting_active) begin
      if (item.move_click) begin
        editing_hour_next = !editing_hour;
        blink_phase_next  = 1'b1;
        blink_count_next  = 8'd0;
      end
      if (item.up_click) begin
        if (editing_hour_next) begin
          edit_hour_next = 5'(wrap_step({1'b0, edit_hour_next}, {1'b0, HOUR_TOP}, 1'b1));
        end else begin
          edit_minute_next = wrap_step(edit_minute_next, MINUTE_TOP, 1'b1);
        end
        blink_phase_next = 1'b1;
        blink_count_next = 8'd0;
        changed          = 1'b1;
      end
      if (item.down_click) begin
        if (editing_hour_next) begin
          edit_hour_next = 5'(wrap_step({1'b0, edit_hour_next}, {1'b0, HOUR_TOP}, 1'b0));
        end else begin
          edit_minute_next = wrap_step(edit_minute_next, MINUTE_TOP, 1'b0);
        end
        blink_phase_next = 1'b1;
        blink_count_next = 8'd0;
        changed          = 1'b1;
      end
    end

    if (item.enable_click) begin
      armed_next = !armed;
      if (armed) begin
        ringing_next    = 1'b0;
        ring_count_next = 8'd0;
      end
      changed = 1'b1;
    end

    if (item.leave_request) begin
      if (setting_active_next) begin
        saved_hour_next     = edit_hour_next;
        saved_minute_next   = edit_minute_next;
        setting_active_next = 1'b0;
        changed             = 1'b1;
      end
      blink_phase_next = 1'b0;
    end

    // Saved time cannot change before this point unless setting mode was left, and
    // the comparison uses the time as it stands after the button handling.
    if (item.second_tick) begin
      if (ringing_next) begin
        ring_count_next = sat_inc(ring_count_next);
        if (ring_count_next >= cfg.ring_duration_seconds) begin
          ringing_next    = 1'b0;
          ring_count_next = 8'd0;
        end
      end else if (armed_next && (item.now_hour == saved_hour_next)
                   && (item.now_minute == saved_minute_next)
                   && (item.now_second == 6'd0)) begin
        ringing_next    = 1'b1;
        ring_count_next = 8'd0;
      end
    end

    if (item.centi_tick && setting_active_next) begin
      blink_count_next = sat_inc(blink_count_next);
      if (blink_count_next >= cfg.blink_half_period_ticks) begin
        blink_count_next = 8'd0;
        blink_phase_next = !blink_phase_next;
      end
    end
  end

  always_comb begin
    result.shown_hour      = setting_active_next ? edit_hour_next : saved_hour_next;
    result.shown_minute    = setting_active_next ? edit_minute_next : saved_minute_next;
    result.is_enabled      = armed_next;
    result.is_sounding     = ringing_next;
    result.in_setting      = setting_active_next;
    result.cursor_shown    = setting_active_next && blink_phase_next;
    result.cursor_on_hour  = editing_hour_next;
    result.display_changed = changed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saved_hour     <= 5'd0;
      saved_minute   <= 6'd0;
      edit_hour      <= 5'd0;
      edit_minute    <= 6'd0;
      setting_active <= 1'b0;
      editing_hour   <= 1'b0;
      armed          <= 1'b0;
      ringing        <= 1'b0;
      ring_count     <= 8'd0;
      blink_phase    <= 1'b0;
      blink_count    <= 8'd0;
    end else if (step) begin
      saved_hour     <= saved_hour_next;
      saved_minute   <= saved_minute_next;
      edit_hour      <= edit_hour_next;
      edit_minute    <= edit_minute_next;
      setting_active <= setting_active_next;
      editing_hour   <= editing_hour_next;
      armed          <= armed_next;
      ringing        <= ringing_next;
      ring_count     <= ring_count_next;
      blink_phase    <= blink_phase_next;
      blink_count    <= blink_count_next;
    end
  end

endmodule

`default_nettype wire

@@ design/alarm_clock_controller.sv @@
// Top level of the alarm clock controller: input register, update core and result register.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall    in_data   (alclk_pkg::in_item_t)
//   out       output     out_valid / out_stall  out_data  (alclk_pkg::out_item_t)
//   config    input      psel/penable/pwrite    paddr, pwdata, prdata
//
// A transaction is registered on acceptance and its result is registered in the result
// register when the core advances; one transaction is taken every cycle unless stalled.
// The rate is set by the single pass of the update logic between the two registers.
// Reset is synchronous and clears all control state and both valid flags.
// A stall on the output holds the result and, once the input register is full, the input.
`timescale 1ns / 1ps
`default_nettype none

module alarm_clock_controller (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire alclk_pkg::in_item_t         in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output alclk_pkg::out_item_t             out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [alclk_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import alclk_pkg::*;

  cfg_t      cfg;
  in_item_t  in_reg;
  logic      in_reg_valid;
  out_item_t result;
  logic      advance;

  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;

  alclk_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  alclk_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_reg),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

@@ sim/alarm_checker.sv @@
// Checker for the alarm clock controller: predicts each displayed state and compares it.
`timescale 1ns / 1ps

module alarm_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  alclk_pkg::in_item_t               in_data,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  alclk_pkg::out_item_t              out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic                         pready,
  input  wire logic [alclk_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output int                                mismatches,
  output int                                pending
);
  import alclk_pkg::*;

  logic [7:0] ring_limit;
  logic [7:0] blink_limit;
  logic [4:0] keep_hr;
  logic [5:0] keep_mn;
  logic [4:0] draft_hr;
  logic [5:0] draft_mn;
  logic       in_set;
  logic       sel_hr;
  logic       arm;
  logic       ring;
  logic [7:0] ring_secs;
  logic       blink_on;
  logic [7:0] blink_ticks;

  out_item_t expected_displays[$];

  function automatic logic [5:0] roll(input logic [5:0] v, input logic [5:0] top,
                                      input logic inc);
    if (inc) begin
      return (v >= top) ? 6'd0 : v + 6'd1;
    end
    return (v == 6'd0) ? top : v - 6'd1;
  endfunction

  function automatic void nudge(input logic inc);
    if (sel_hr) begin
      draft_hr = 5'(roll({1'b0, draft_hr}, {1'b0, HOUR_TOP}, inc));
    end else begin
      draft_mn = roll(draft_mn, MINUTE_TOP, inc);
    end
    blink_on = 1'b1;
    blink_ticks = 8'd0;
  endfunction

  function automatic logic leave_edit();
    logic was;
    was = in_set;
    if (in_set) begin
      keep_hr = draft_hr;
      keep_mn = draft_mn;
      in_set = 1'b0;
    end
    blink_on = 1'b0;
    return was;
  endfunction

  function automatic out_item_t predict_display(input in_item_t t);
    out_item_t r;
    logic changed;
    changed = 1'b0;
    if (t.function_click) begin
      if (!in_set) begin
        draft_hr = keep_hr;
        draft_mn = keep_mn;
        in_set = 1'b1;
        sel_hr = 1'b0;
        blink_on = 1'b1;
        blink_ticks = 8'd0;
      end else begin
        void'(leave_edit());
      end
      changed = 1'b1;
    end else if (in_set) begin
      if (t.move_click) begin
        sel_hr = !sel_hr;
        blink_on = 1'b1;
        blink_ticks = 8'd0;
      end
      if (t.up_click) begin
        nudge(1'b1);
        changed = 1'b1;
      end
      if (t.down_click) begin
        nudge(1'b0);
        changed = 1'b1;
      end
    end
    if (t.enable_click) begin
      arm = !arm;
      if (!arm) begin
        ring = 1'b0;
        ring_secs = 8'd0;
      end
      changed = 1'b1;
    end
    if (t.leave_request) begin
      if (leave_edit()) changed = 1'b1;
    end
    if (t.second_tick) begin
      if (ring) begin
        if (ring_secs < COUNT_MAX) ring_secs = ring_secs + 8'd1;
        if (ring_secs >= ring_limit) begin
          ring = 1'b0;
          ring_secs = 8'd0;
        end
      end else if (arm && t.now_hour == keep_hr && t.now_minute == keep_mn &&
                   t.now_second == 6'd0) begin
        ring = 1'b1;
        ring_secs = 8'd0;
      end
    end
    if (t.centi_tick && in_set) begin
      if (blink_ticks < COUNT_MAX) blink_ticks = blink_ticks + 8'd1;
      if (blink_ticks >= blink_limit) begin
        blink_ticks = 8'd0;
        blink_on = !blink_on;
      end
    end
    r.shown_hour = in_set ? draft_hr : keep_hr;
    r.shown_minute = in_set ? draft_mn : keep_mn;
    r.is_enabled = arm;
    r.is_sounding = ring;
    r.in_setting = in_set;
    r.cursor_shown = in_set && blink_on;
    r.cursor_on_hour = sel_hr;
    r.display_changed = changed;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      ring_limit = RING_RESET;
      blink_limit = BLINK_RESET;
      keep_hr = '0;
      keep_mn = '0;
      draft_hr = '0;
      draft_mn = '0;
      in_set = 1'b0;
      sel_hr = 1'b0;
      arm = 1'b0;
      ring = 1'b0;
      ring_secs = '0;
      blink_on = 1'b0;
      blink_ticks = '0;
      expected_displays.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_displays.size() == 0) begin
          $error("result arrived with no transaction waiting for it");
          mismatches++;
        end else begin
          want = expected_displays.pop_front();
          check_field("shown_hour", 8'(want.shown_hour), 8'(out_data.shown_hour));
          check_field("shown_minute", 8'(want.shown_minute), 8'(out_data.shown_minute));
          check_field("is_enabled", 8'(want.is_enabled), 8'(out_data.is_enabled));
          check_field("is_sounding", 8'(want.is_sounding), 8'(out_data.is_sounding));
          check_field("in_setting", 8'(want.in_setting), 8'(out_data.in_setting));
          check_field("cursor_shown", 8'(want.cursor_shown), 8'(out_data.cursor_shown));
          check_field("cursor_on_hour", 8'(want.cursor_on_hour),
                      8'(out_data.cursor_on_hour));
          check_field("display_changed", 8'(want.display_changed),
                      8'(out_data.display_changed));
        end
      end
      if (in_valid && !in_stall) expected_displays.push_back(predict_display(in_data));
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_RING_DURATION) begin
          ring_limit = pwdata[7:0];
        end else begin
          blink_limit = pwdata[7:0];
        end
      end
    end
    pending = expected_displays.size();
  end

endmodule

@@ sim/tb.sv @@
// Top of the alarm clock controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import alclk_pkg::*;

  localparam int CLOCK_LIMIT = 800000;

  localparam logic [6:0] K_FN  = 7'b1000000;
  localparam logic [6:0] K_MV  = 7'b0100000;
  localparam logic [6:0] K_UP  = 7'b0010000;
  localparam logic [6:0] K_DN  = 7'b0001000;
  localparam logic [6:0] K_EN  = 7'b0000100;
  localparam logic [6:0] K_LV  = 7'b0000010;
  localparam logic [6:0] K_SEC = 7'b0000001;
  localparam logic [6:0] K_ALL = 7'b1111111;
  localparam logic [6:0] K_NONE = 7'b0000000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int mismatches;
  int pending;
  int cycles = 0;
  int sent = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  logic [7:0] ring_cfg = RING_RESET;
  logic [7:0] blink_cfg = BLINK_RESET;
  logic [4:0] seen_hour = '0;
  logic [5:0] seen_minute = '0;
  logic       seen_enabled = 1'b0;
  logic       seen_setting = 1'b0;

  alarm_clock_controller uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  alarm_checker watch (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CLOCK_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic logic chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [4:0] rnd_hour();
    return 5'($urandom_range(0, 23));
  endfunction

  function automatic logic [5:0] rnd_sixty();
    return 6'($urandom_range(0, 59));
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_item(input logic [6:0] keys, input logic [4:0] h,
                                         input logic [5:0] m, input logic [5:0] s,
                                         input logic ct);
    in_item_t it;
    {it.function_click, it.move_click, it.up_click, it.down_click, it.enable_click,
     it.leave_request, it.second_tick} = keys;
    it.now_hour = h;
    it.now_minute = m;
    it.now_second = s;
    it.centi_tick = ct;
    return it;
  endfunction

  // The receiver stalls in bursts; the last committed alarm state is kept for stimulus.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      seen_enabled = out_data.is_enabled;
      seen_setting = out_data.in_setting;
      seen_hour = out_data.shown_hour;
      seen_minute = out_data.shown_minute;
    end
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (chance(70)) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = chance(85) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      out_stall <= 1'b1;
    end
  end

  task automatic send(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_config(input logic [7:0] ring_val, input logic [7:0] blink_val);
    drain();
    for (int i = 0; i < 2; i++) begin
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= (i == 0) ? {REG_RING_DURATION, 2'b00} : {REG_BLINK_HALF, 2'b00};
      pwdata <= {24'd0, (i == 0) ? ring_val : blink_val};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    ring_cfg = ring_val;
    blink_cfg = blink_val;
  endtask

  task automatic random_session();
    int kind;
    int n;
    logic [6:0] keys;
    logic [4:0] h;
    logic [5:0] m;
    logic [5:0] s;
    kind = $urandom_range(0, 99);
    calm = chance(15);
    if (kind < 35) begin
      keys = K_FN | (chance(30) ? (7'($urandom) & (K_MV | K_UP | K_DN)) : K_NONE);
      send(make_item(keys, rnd_hour(), rnd_sixty(), rnd_sixty(), chance(50)));
      n = $urandom_range(1, 12);
      repeat (n) begin
        keys = K_NONE;
        if (chance(25)) keys |= K_MV;
        if (chance(35)) keys |= K_UP;
        if (chance(35)) keys |= K_DN;
        if (chance(4)) keys |= K_EN;
        if (chance(20)) keys |= K_SEC;
        send(make_item(keys, rnd_hour(), rnd_sixty(), rnd_sixty(), chance(50)));
      end
      n = $urandom_range(0, 9);
      keys = (n < 4) ? K_FN : (n < 8) ? K_LV : (n == 8) ? (K_FN | K_LV) : K_NONE;
      send(make_item(keys, rnd_hour(), rnd_sixty(), rnd_sixty(), chance(50)));
    end else if (kind < 65) begin
      drain();
      if (seen_setting) send(make_item(K_LV, rnd_hour(), rnd_sixty(), rnd_sixty(), 1'b0));
      if (!seen_enabled) send(make_item(K_EN, rnd_hour(), rnd_sixty(), rnd_sixty(), 1'b0));
      h = seen_hour;
      m = seen_minute;
      if (chance(10)) h = (h == HOUR_TOP) ? 5'd0 : h + 5'd1;
      s = 6'd0;
      n = $urandom_range(1, int'(ring_cfg) + 4);
      repeat (n) begin
        keys = chance(90) ? K_SEC : K_NONE;
        if (chance(3)) keys |= K_EN;
        send(make_item(keys, h, m, s, chance(30)));
        s = (chance(5) || s == MINUTE_TOP) ? 6'd0 : s + 6'd1;
      end
    end else if (kind < 75) begin
      drain();
      if (!seen_setting) send(make_item(K_FN, rnd_hour(), rnd_sixty(), rnd_sixty(), 1'b0));
      n = $urandom_range(1, 2 * int'(blink_cfg) + 4);
      repeat (n) begin
        send(make_item(chance(10) ? K_SEC : K_NONE, rnd_hour(), rnd_sixty(), rnd_sixty(),
                       chance(85)));
      end
      send(make_item(chance(50) ? K_FN : K_LV, rnd_hour(), rnd_sixty(), rnd_sixty(),
                     chance(50)));
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        send(make_item(7'($urandom), rnd_hour(), rnd_sixty(), rnd_sixty(), 1'($urandom)));
      end
    end
  endtask

  initial begin
    int ring_set[7] = '{60, 1, 255, 2, 0, 3, 255};
    int blink_set[7] = '{50, 1, 255, 3, 0, 255, 1};
    int goal;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Clicks outside setting mode, edit wrap in both fields, commit, then the ring start.
    send(make_item(K_NONE, 5'd0, 6'd0, 6'd0, 1'b0));
    send(make_item(K_LV, 5'd12, 6'd34, 6'd56, 1'b1));
    send(make_item(K_MV | K_UP | K_DN, 5'd7, 6'd8, 6'd9, 1'b1));
    send(make_item(K_FN | K_MV | K_UP | K_DN, 5'd1, 6'd2, 6'd3, 1'b1));
    send(make_item(K_DN, 5'd0, 6'd0, 6'd0, 1'b0));
    send(make_item(K_UP, 5'd0, 6'd0, 6'd0, 1'b1));
    send(make_item(K_DN, 5'd0, 6'd0, 6'd0, 1'b0));
    send(make_item(K_MV | K_DN, 5'd0, 6'd0, 6'd0, 1'b0));
    send(make_item(K_UP, 5'd0, 6'd0, 6'd0, 1'b0));
    send(make_item(K_DN, 5'd0, 6'd0, 6'd0, 1'b1));
    send(make_item(K_UP | K_DN, 5'd0, 6'd0, 6'd0, 1'b0));
    send(make_item(K_LV, 5'd0, 6'd0, 6'd0, 1'b0));
    send(make_item(K_EN, 5'd0, 6'd0, 6'd0, 1'b0));
    send(make_item(K_SEC, 5'd23, 6'd59, 6'd59, 1'b0));
    send(make_item(K_SEC, 5'd23, 6'd59, 6'd0, 1'b0));
    send(make_item(K_SEC, 5'd23, 6'd59, 6'd0, 1'b1));
    send(make_item(K_FN | K_EN | K_LV | K_SEC, 5'd23, 6'd59, 6'd0, 1'b1));
    send(make_item(K_EN | K_SEC, 5'd0, 6'd0, 6'd0, 1'b0));
    send(make_item(K_FN | K_LV, 5'd0, 6'd0, 6'd0, 1'b1));
    send(make_item(K_FN, 5'd0, 6'd0, 6'd0, 1'b0));
    send(make_item(K_MV | K_UP, 5'd0, 6'd0, 6'd0, 1'b1));
    send(make_item(K_FN | K_EN, 5'd0, 6'd0, 6'd0, 1'b1));
    send(make_item(K_SEC, 5'd16, 6'd32, 6'd32, 1'b1));
    send(make_item(K_ALL, 5'd23, 6'd59, 6'd59, 1'b1));

    ring_set[4] = $urandom_range(1, 255);
    blink_set[4] = $urandom_range(1, 255);
    foreach (ring_set[p]) begin
      load_config(8'(ring_set[p]), 8'(blink_set[p]));
      goal = sent + 160;
      while (sent < goal) random_session();
    end
    drain();
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
